/* rtl/core/pgt_pkg.sv */
// Shared definitions for the palette gradient table: field widths, command codes,
// item and result structs, and the controller/datapath command and status types.
// No dependencies.
package pgt_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_TABLE_DEPTH  = 256;
  localparam int DEF_CHANNEL_BITS = 8;

  // Fixed field widths of the channel payloads.
  localparam int OP_W    = 2;
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 8;
  localparam int COUNT_W = 9;

  // Number of color channels per palette entry.
  localparam int NUM_CH = 3;
  localparam logic [1:0] CH_LAST = 2'd2;

  // Command codes carried in the op field.
  localparam logic [OP_W-1:0] OP_READ     = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE    = 2'd1;
  localparam logic [OP_W-1:0] OP_GRADIENT = 2'd2;

  // Result status codes.
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // One input transaction.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [IDX_W-1:0]   index_a;
    logic [IDX_W-1:0]   index_b;
    logic [COLOR_W-1:0] red_a;
    logic [COLOR_W-1:0] green_a;
    logic [COLOR_W-1:0] blue_a;
    logic [COLOR_W-1:0] red_b;
    logic [COLOR_W-1:0] green_b;
    logic [COLOR_W-1:0] blue_b;
  } pgt_item_t;

  // One result transaction.
  typedef struct packed {
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;
    logic               status;
  } pgt_result_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FILL,
    ST_DONE
  } pgt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic       wr_item;
    logic       div_start;
    logic       div_capture;
    logic [1:0] div_ch;
    logic       fill_step;
    logic       out_load;
  } pgt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ok;
    logic            div_done;
    logic            fill_last;
    logic            out_free;
    logic            cfg_busy;
  } pgt_stat_t;

endpackage

/* rtl/core/pgt_in_if.sv */
// Input channel of the palette gradient table: valid/ready handshake and the
// command payload. Depends on pgt_pkg for the field widths.
interface pgt_in_if;
  import pgt_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [IDX_W-1:0]   index_a;
  logic [IDX_W-1:0]   index_b;
  logic [COLOR_W-1:0] red_a;
  logic [COLOR_W-1:0] green_a;
  logic [COLOR_W-1:0] blue_a;
  logic [COLOR_W-1:0] red_b;
  logic [COLOR_W-1:0] green_b;
  logic [COLOR_W-1:0] blue_b;

  modport source (
    output valid, op, index_a, index_b, red_a, green_a, blue_a, red_b, green_b, blue_b,
    input  ready
  );

  modport sink (
    input  valid, op, index_a, index_b, red_a, green_a, blue_a, red_b, green_b, blue_b,
    output ready
  );

endinterface

/* rtl/core/pgt_out_if.sv */
// Result channel of the palette gradient table: valid/ready handshake and the
// result payload. Depends on pgt_pkg for the field widths.
interface pgt_out_if;
  import pgt_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red_out;
  logic [COLOR_W-1:0] green_out;
  logic [COLOR_W-1:0] blue_out;
  logic               status;

  modport source (
    output valid, red_out, green_out, blue_out, status,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out, status,
    output ready
  );

endinterface

/* rtl/core/pgt_divider.sv */
// Serial restoring divider: one quotient bit per cycle, used to split a channel
// difference into a per-entry step quotient and remainder. Depends on pgt_pkg.
module pgt_divider #(
  parameter int CHANNEL_BITS = pgt_pkg::DEF_CHANNEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [CHANNEL_BITS-1:0]   dividend,
  input  logic [pgt_pkg::IDX_W-1:0] divisor,
  output logic                      done,
  output logic [CHANNEL_BITS-1:0]   quotient,
  output logic [pgt_pkg::IDX_W-1:0] remainder
);
  import pgt_pkg::*;

  localparam int CNT_W = $clog2(CHANNEL_BITS + 1);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        rem_r, rem_nxt;
  logic [CHANNEL_BITS-1:0] quo_r, quo_nxt;
  logic [IDX_W:0]          trial;
  logic                    fits;

  // One restoring step: bring in the next dividend bit and try to subtract.
  always_comb begin
    trial    = {rem_r, quo_r[CHANNEL_BITS-1]};
    fits     = (trial >= {1'b0, divisor});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? IDX_W'(trial - {1'b0, divisor}) : IDX_W'(trial);
      quo_nxt = CHANNEL_BITS'({quo_r, fits});
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(CHANNEL_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* rtl/core/pgt_datapath.sv */
// Datapath of the palette gradient table: palette memory, count register and
// clearing sweep, gradient interpolator with its divider, and the result register.
// Depends on pgt_pkg and pgt_divider.
module pgt_datapath #(
  parameter int TABLE_DEPTH  = pgt_pkg::DEF_TABLE_DEPTH,
  parameter int CHANNEL_BITS = pgt_pkg::DEF_CHANNEL_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pgt_pkg::COUNT_W-1:0] cfg_data,
  input  pgt_pkg::pgt_item_t          in_item,
  input  pgt_pkg::pgt_cmd_t           cmd,
  output pgt_pkg::pgt_stat_t          stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pgt_pkg::pgt_result_t        out_result
);
  import pgt_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CB    = CHANNEL_BITS;
  localparam int EW    = NUM_CH * CB;

  // Held command and count state.
  pgt_item_t        item_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] sweep_ptr_r, sweep_ptr_nxt;
  logic [CNT_W-1:0] cfg_n;
  logic             sweep_busy;
  logic             ok;
  logic [IDX_W-1:0] span;

  // Gradient walk state.
  logic [IDX_W-1:0] idx_r;
  logic [CB-1:0]    qs_r  [NUM_CH];
  logic [IDX_W-1:0] rs_r  [NUM_CH];
  logic [CB-1:0]    q_r   [NUM_CH];
  logic [IDX_W-1:0] rem_r [NUM_CH];
  logic [CB-1:0]    q_nxt   [NUM_CH];
  logic [IDX_W-1:0] rem_nxt [NUM_CH];
  logic [CB-1:0]    ca [NUM_CH];
  logic [CB-1:0]    cb [NUM_CH];
  logic [CB-1:0]    mag [NUM_CH];
  logic             neg [NUM_CH];
  logic [CB-1:0]    fill_val [NUM_CH];
  logic [IDX_W:0]   rsum [NUM_CH];
  logic             carry [NUM_CH];

  // Divider hookup.
  logic [CB-1:0]    div_dividend;
  logic             div_done;
  logic [CB-1:0]    div_quo;
  logic [IDX_W-1:0] div_rem;

  // Memory.
  logic [EW-1:0]    mem [TABLE_DEPTH];
  logic [EW-1:0]    rdata_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [EW-1:0]    mem_wdata;
  logic [EW-1:0]    item_wdata;
  logic [EW-1:0]    fill_wdata;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  pgt_result_t      res_r;
  pgt_result_t      res_nxt;

  // Channel colors reduced to the stored width, and the gradient difference.
  always_comb begin
    ca[0] = CB'(item_r.red_a);
    ca[1] = CB'(item_r.green_a);
    ca[2] = CB'(item_r.blue_a);
    cb[0] = CB'(item_r.red_b);
    cb[1] = CB'(item_r.green_b);
    cb[2] = CB'(item_r.blue_b);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      neg[ch] = (cb[ch] < ca[ch]);
      mag[ch] = neg[ch] ? (ca[ch] - cb[ch]) : (cb[ch] - ca[ch]);
    end
  end

  assign span = item_r.index_b - item_r.index_a;

  // Range checks against the active count.
  always_comb begin
    case (item_r.op)
      OP_READ, OP_WRITE: ok = (32'(item_r.index_a) < 32'(count_r));
      OP_GRADIENT:       ok = (item_r.index_a < item_r.index_b) &&
                              (32'(item_r.index_b) < 32'(count_r));
      default:           ok = 1'b0;
    endcase
  end

  // Divider operand select for the channel being worked on.
  always_comb begin
    case (cmd.div_ch)
      2'd1:    div_dividend = mag[1];
      2'd2:    div_dividend = mag[2];
      default: div_dividend = mag[0];
    endcase
  end

  pgt_divider #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Incremental interpolator: q tracks floor(i*|diff|/span), rem the fraction.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      fill_val[ch] = neg[ch] ? (ca[ch] - q_r[ch]) : (ca[ch] + q_r[ch]);
      rsum[ch]     = (IDX_W + 1)'(rem_r[ch]) + (IDX_W + 1)'(rs_r[ch]);
      carry[ch]    = (rsum[ch] >= {1'b0, span});
      rem_nxt[ch]  = carry[ch] ? IDX_W'(rsum[ch] - {1'b0, span}) : IDX_W'(rsum[ch]);
      q_nxt[ch]    = q_r[ch] + qs_r[ch] + CB'(carry[ch]);
    end
  end

  // Item and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      idx_r  <= in_item.index_a;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        q_r[ch]   <= '0;
        rem_r[ch] <= '0;
      end
    end else if (cmd.fill_step) begin
      idx_r <= idx_r + IDX_W'(1);
      for (int ch = 0; ch < NUM_CH; ch++) begin
        q_r[ch]   <= q_nxt[ch];
        rem_r[ch] <= rem_nxt[ch];
      end
    end
  end

  // Step quotient and remainder per channel, captured as the divider finishes.
  always_ff @(posedge clk) begin
    if (cmd.div_capture) begin
      case (cmd.div_ch)
        2'd1: begin
          qs_r[1] <= div_quo;
          rs_r[1] <= div_rem;
        end
        2'd2: begin
          qs_r[2] <= div_quo;
          rs_r[2] <= div_rem;
        end
        default: begin
          qs_r[0] <= div_quo;
          rs_r[0] <= div_rem;
        end
      endcase
    end
  end

  // Count write saturates to the depth and pulls the sweep start down to it.
  always_comb begin
    cfg_n         = (32'(cfg_data) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cfg_data);
    sweep_busy    = (32'(sweep_ptr_r) < TABLE_DEPTH);
    count_nxt     = count_r;
    sweep_ptr_nxt = sweep_ptr_r;
    if (cfg_we) begin
      count_nxt     = cfg_n;
      sweep_ptr_nxt = (sweep_ptr_r < cfg_n) ? sweep_ptr_r : cfg_n;
    end else if (sweep_busy) begin
      sweep_ptr_nxt = sweep_ptr_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CNT_W'(TABLE_DEPTH);
      sweep_ptr_r <= '0;
    end else begin
      count_r     <= count_nxt;
      sweep_ptr_r <= sweep_ptr_nxt;
    end
  end

  // Memory write select: clearing sweep, single-entry write or gradient step.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      item_wdata[ch*CB +: CB] = ca[ch];
      fill_wdata[ch*CB +: CB] = fill_val[ch];
    end
    mem_we    = 1'b0;
    mem_waddr = sweep_ptr_r[AW-1:0];
    mem_wdata = '0;
    if (sweep_busy) begin
      mem_we = 1'b1;
    end else if (cmd.wr_item) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(item_r.index_a);
      mem_wdata = item_wdata;
    end else if (cmd.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(idx_r);
      mem_wdata = fill_wdata;
    end
  end

  // Palette memory, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[AW'(item_r.index_a)];
    end
  end

  // Result register and its valid flag.
  always_comb begin
    res_nxt        = '0;
    res_nxt.status = ok ? STATUS_DONE : STATUS_REJECT;
    if (ok && (item_r.op == OP_READ)) begin
      res_nxt.red_out   = COLOR_W'(rdata_r[0*CB +: CB]);
      res_nxt.green_out = COLOR_W'(rdata_r[1*CB +: CB]);
      res_nxt.blue_out  = COLOR_W'(rdata_r[2*CB +: CB]);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_r <= res_nxt;
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.op        = item_r.op;
    stat.ok        = ok;
    stat.div_done  = div_done;
    stat.fill_last = (idx_r == item_r.index_b);
    stat.out_free  = !out_valid_r || out_ready;
    stat.cfg_busy  = cfg_we || sweep_busy;
  end

  assign out_valid  = out_valid_r;
  assign out_result = res_r;

endmodule

/* rtl/core/pgt_ctrl.sv */
// Controller of the palette gradient table: sequences range check, memory access,
// per-channel division and the gradient walk. Depends on pgt_pkg.
module pgt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pgt_pkg::pgt_stat_t stat,
  output pgt_pkg::pgt_cmd_t  cmd
);
  import pgt_pkg::*;

  pgt_state_t state_r, state_nxt;
  logic [1:0] ch_r, ch_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    ch_nxt     = ch_r;
    cmd        = '0;
    cmd.div_ch = ch_r;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !stat.cfg_busy;
        if (in_valid && !stat.cfg_busy) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        if (stat.ok) begin
          case (stat.op)
            OP_READ:  cmd.rd_en   = 1'b1;
            OP_WRITE: cmd.wr_item = 1'b1;
            OP_GRADIENT: begin
              ch_nxt    = '0;
              state_nxt = ST_DIV_GO;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_capture = 1'b1;
          if (ch_r == CH_LAST) begin
            state_nxt = ST_FILL;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/palette_gradient_table_top.sv */
// Palette gradient table. Read and write pass from acceptance through the execute and
// done states to a valid result; a gradient from a to b runs the serial divider once per
// channel (one quotient bit a cycle per channel), then writes one entry per cycle
// on the memory write port. One transaction is worked on at a time; the next is taken
// while a result waits. After reset a clearing sweep of all TABLE_DEPTH entries runs, and a
// count write of n clears the entries from n up to TABLE_DEPTH-1; no transaction is accepted meanwhile.
module palette_gradient_table_top #(
  parameter int TABLE_DEPTH  = pgt_pkg::DEF_TABLE_DEPTH,
  parameter int CHANNEL_BITS = pgt_pkg::DEF_CHANNEL_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pgt_pkg::COUNT_W-1:0] cfg_data,
  pgt_in_if.sink                      in_ch,
  pgt_out_if.source                   out_ch
);
  import pgt_pkg::*;

  pgt_item_t   in_item;
  pgt_result_t out_result;
  pgt_cmd_t    cmd;
  pgt_stat_t   stat;
  logic        in_ready;
  logic        out_valid;

  // Gather the input payload.
  always_comb begin
    in_item.op      = in_ch.op;
    in_item.index_a = in_ch.index_a;
    in_item.index_b = in_ch.index_b;
    in_item.red_a   = in_ch.red_a;
    in_item.green_a = in_ch.green_a;
    in_item.blue_a  = in_ch.blue_a;
    in_item.red_b   = in_ch.red_b;
    in_item.green_b = in_ch.green_b;
    in_item.blue_b  = in_ch.blue_b;
  end

  pgt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  pgt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_result(out_result)
  );

  // Drive the channel handshakes and result payload.
  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.red_out   = out_result.red_out;
  assign out_ch.green_out = out_result.green_out;
  assign out_ch.blue_out  = out_result.blue_out;
  assign out_ch.status    = out_result.status;

endmodule
